// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define NPV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define NPV_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== sv/npv_pkg.sv =====
`timescale 1ns / 1ps
package npv_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = 11;

	localparam int COORD_W = 16;
	localparam int DIST_W  = 34;
	localparam int VOL_W   = 7;
	localparam int STAT_W  = 2;

	localparam logic [CNT_W-1:0]  MAX_COUNT    = CNT_W'(MAX_POINTS);
	localparam logic [DIST_W-1:0] DIST_NONE    = {DIST_W{1'b1}};
	localparam logic [DIST_W-1:0] RADIUS_RESET = DIST_W'(200000);

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

// ===== sv/npv_volume.sv =====
`timescale 1ns / 1ps
module npv_volume (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [npv_pkg::DIST_W-1:0]       near_sq,
	input  logic [npv_pkg::DIST_W-1:0]       radius,
	output logic                             done,
	output logic [npv_pkg::VOL_W-1:0]        volume
);

	localparam int HALF_W = npv_pkg::DIST_W / 2;
	localparam int SQ_W   = 2 * npv_pkg::DIST_W;
	localparam int NUM_W  = SQ_W + npv_pkg::VOL_W;

	typedef enum logic [2:0] {
		V_IDLE = 3'b001,
		V_MUL  = 3'b010,
		V_DIV  = 3'b100
	} vstate_t;

	vstate_t                     state_q;
	logic [npv_pkg::DIST_W-1:0]  q_q;
	logic [npv_pkg::DIST_W-1:0]  r_q;
	logic [3:0]                  step_q;
	logic [npv_pkg::DIST_W-1:0]  pp_q;
	logic [1:0]                  pp_sh_q;
	logic                        pp_rr_q;
	logic                        pp_vld_q;
	logic [SQ_W-1:0]             qq_q;
	logic [SQ_W-1:0]             rr_q;
	logic [NUM_W-1:0]            rem_q;
	logic [2:0]                  bit_q;
	logic [npv_pkg::VOL_W-1:0]   vol_q;
	logic                        done_q;

	logic [npv_pkg::DIST_W-1:0]  op_a;
	logic [HALF_W-1:0]           pa;
	logic [HALF_W-1:0]           pb;
	logic [SQ_W-1:0]             pp_ext;
	logic [SQ_W-1:0]             pp_shift;
	logic [NUM_W-1:0]            div_t;
	logic                        div_ge;

	assign op_a = step_q[2] ? r_q : q_q;
	assign pa   = step_q[0] ? op_a[npv_pkg::DIST_W-1:HALF_W] : op_a[HALF_W-1:0];
	assign pb   = step_q[1] ? op_a[npv_pkg::DIST_W-1:HALF_W] : op_a[HALF_W-1:0];

	always_comb begin
		pp_ext = {{(SQ_W-npv_pkg::DIST_W){1'b0}}, pp_q};
		case (pp_sh_q)
			2'd0:    pp_shift = pp_ext;
			2'd1:    pp_shift = pp_ext << HALF_W;
			default: pp_shift = pp_ext << (2 * HALF_W);
		endcase
	end

	assign div_t  = {{npv_pkg::VOL_W{1'b0}}, rr_q} << bit_q;
	assign div_ge = rem_q >= div_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= V_IDLE;
			step_q   <= '0;
			pp_vld_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				V_IDLE: begin
					pp_vld_q <= 1'b0;
					if (start) begin
						if (near_sq >= radius) begin
							done_q <= 1'b1;
						end else begin
							step_q  <= '0;
							state_q <= V_MUL;
						end
					end
				end
				V_MUL: begin
					if (step_q == 4'd8) begin
						pp_vld_q <= 1'b0;
						state_q  <= V_DIV;
					end else begin
						pp_vld_q <= 1'b1;
						step_q   <= step_q + 4'd1;
					end
				end
				V_DIV: begin
					if (bit_q == 3'd0) begin
						done_q  <= 1'b1;
						state_q <= V_IDLE;
					end
				end
				default: state_q <= V_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == V_IDLE && start) begin
			q_q   <= radius - near_sq;
			r_q   <= radius;
			qq_q  <= '0;
			rr_q  <= '0;
			vol_q <= '0;
		end
		if (state_q == V_MUL && step_q != 4'd8) begin
			pp_q    <= pa * pb;
			pp_sh_q <= {1'b0, step_q[0]} + {1'b0, step_q[1]};
			pp_rr_q <= step_q[2];
		end
		if (pp_vld_q) begin
			if (pp_rr_q) begin
				rr_q <= rr_q + pp_shift;
			end else begin
				qq_q <= qq_q + pp_shift;
			end
		end
		if (state_q == V_MUL && step_q == 4'd8) begin
			rem_q <= {qq_q, {npv_pkg::VOL_W{1'b0}}} - {{npv_pkg::VOL_W{1'b0}}, qq_q};
			bit_q <= 3'(npv_pkg::VOL_W - 1);
		end
		if (state_q == V_DIV) begin
			if (div_ge) begin
				rem_q        <= rem_q - div_t;
				vol_q[bit_q] <= 1'b1;
			end
			bit_q <= bit_q - 3'd1;
		end
	end

	assign done   = done_q;
	assign volume = vol_q;

endmodule

// ===== sv/nearest_point_proximity_volume_core.sv =====
// Nearest-point proximity volume. An append item stores one point in a
// 1024-entry memory, unless it is full, and its result comes out the
// cycle after start; busy stays low, so appends can follow every cycle.
// A query item scans the stored points through the memory's single
// read port, one point per cycle, then runs the volume unit (multiply
// steps on a shared 17x17 multiplier and seven restoring divide
// steps). A query on an empty store or one whose nearest distance is
// not below the radius skips the volume steps. Every result is shown
// for exactly one cycle with done high and must be captured then,
// since the receiver has no way to stall it. The user must write
// falloff_radius_sq (radius_q) through cfg_wr_en and cfg_wr_data only
// while busy is low; the block itself does not enforce it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nearest_point_proximity_volume_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              opcode,
	input  logic signed [npv_pkg::COORD_W-1:0] x_coord,
	input  logic signed [npv_pkg::COORD_W-1:0] y_coord,
	input  logic signed [npv_pkg::COORD_W-1:0] z_coord,
	input  logic                              cfg_wr_en,
	input  logic [npv_pkg::DIST_W-1:0]        cfg_wr_data,
	output logic                              done,
	output logic [npv_pkg::STAT_W-1:0]        status,
	output logic [npv_pkg::VOL_W-1:0]         volume,
	output logic [npv_pkg::DIST_W-1:0]        min_dist_sq,
	output logic [npv_pkg::CNT_W-1:0]         point_count
);

	localparam int CW  = npv_pkg::COORD_W;
	localparam int PW  = 3 * CW;
	localparam int SQW = 2 * CW;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_VOL  = 3'b100
	} state_t;

	state_t                         state_q;
	logic [npv_pkg::DIST_W-1:0]     radius_q;
	logic [npv_pkg::CNT_W-1:0]      count_q;
	logic [npv_pkg::CNT_W-1:0]      idx_q;
	logic signed [CW-1:0]           lx_q;
	logic signed [CW-1:0]           ly_q;
	logic signed [CW-1:0]           lz_q;
	logic [npv_pkg::DIST_W-1:0]     best_q;

	logic [PW-1:0]                  mem [npv_pkg::MAX_POINTS];
	logic [PW-1:0]                  rdata_s1;
	logic                           vld_s1;
	logic [CW-1:0]                  ax_s2;
	logic [CW-1:0]                  ay_s2;
	logic [CW-1:0]                  az_s2;
	logic                           vld_s2;
	logic [SQW-1:0]                 sqx_s3;
	logic [SQW-1:0]                 sqy_s3;
	logic [SQW-1:0]                 sqz_s3;
	logic                           vld_s3;

	logic                           done_q;
	logic [npv_pkg::STAT_W-1:0]     status_q;
	logic [npv_pkg::VOL_W-1:0]      volume_q;
	logic [npv_pkg::DIST_W-1:0]     dist_q;
	logic [npv_pkg::CNT_W-1:0]      pcount_q;

	logic                           accept;
	logic                           wr_en;
	logic                           rd_en;
	logic                           scan_end;
	logic                           full;
	logic signed [CW:0]             dx;
	logic signed [CW:0]             dy;
	logic signed [CW:0]             dz;
	logic [CW:0]                    mx;
	logic [CW:0]                    my;
	logic [CW:0]                    mz;
	logic [npv_pkg::DIST_W-1:0]     sum_s3;
	logic                           vol_start;
	logic                           vol_done;
	logic [npv_pkg::VOL_W-1:0]      vol_value;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign full     = (count_q >= npv_pkg::MAX_COUNT);
	assign wr_en    = accept && (opcode == npv_pkg::OP_APPEND) && !full;
	assign rd_en    = (state_q == ST_SCAN) && (idx_q < count_q);
	assign scan_end = (state_q == ST_SCAN) && (idx_q == count_q)
		&& !vld_s1 && !vld_s2 && !vld_s3;
	assign vol_start = scan_end;

	// point memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[npv_pkg::ADDR_W-1:0]] <= {x_coord, y_coord, z_coord};
		end
		if (rd_en) begin
			rdata_s1 <= mem[idx_q[npv_pkg::ADDR_W-1:0]];
		end
	end

	assign dx = {rdata_s1[PW-1], rdata_s1[PW-1:2*CW]} - {lx_q[CW-1], lx_q};
	assign dy = {rdata_s1[2*CW-1], rdata_s1[2*CW-1:CW]} - {ly_q[CW-1], ly_q};
	assign dz = {rdata_s1[CW-1], rdata_s1[CW-1:0]} - {lz_q[CW-1], lz_q};
	assign mx = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
	assign my = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
	assign mz = dz[CW] ? (CW+1)'(-dz) : (CW+1)'(dz);

	assign sum_s3 = {2'b00, sqx_s3} + {2'b00, sqy_s3} + {2'b00, sqz_s3};

	always_ff @(posedge clk) begin
		ax_s2  <= mx[CW-1:0];
		ay_s2  <= my[CW-1:0];
		az_s2  <= mz[CW-1:0];
		sqx_s3 <= ax_s2 * ax_s2;
		sqy_s3 <= ay_s2 * ay_s2;
		sqz_s3 <= az_s2 * az_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	npv_volume u_volume (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (vol_start),
		.near_sq (best_q),
		.radius  (radius_q),
		.done    (vol_done),
		.volume  (vol_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			radius_q <= npv_pkg::RADIUS_RESET;
			count_q  <= '0;
			idx_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr_en) begin
				radius_q <= cfg_wr_data;
			end
			if (wr_en) begin
				count_q <= count_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (opcode == npv_pkg::OP_APPEND) begin
							done_q <= 1'b1;
						end else if (count_q == '0) begin
							done_q <= 1'b1;
						end else begin
							idx_q   <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						idx_q <= idx_q + 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_VOL;
					end
				end
				ST_VOL: begin
					if (vol_done) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload and scan data
	always_ff @(posedge clk) begin
		if (accept) begin
			lx_q   <= x_coord;
			ly_q   <= y_coord;
			lz_q   <= z_coord;
			best_q <= npv_pkg::DIST_NONE;
			if (opcode == npv_pkg::OP_APPEND) begin
				status_q <= full ? npv_pkg::STATUS_FULL : npv_pkg::STATUS_OK;
				volume_q <= '0;
				dist_q   <= '0;
				pcount_q <= full ? count_q : count_q + 1'b1;
			end else begin
				status_q <= npv_pkg::STATUS_EMPTY;
				volume_q <= '0;
				dist_q   <= npv_pkg::DIST_NONE;
				pcount_q <= count_q;
			end
		end
		if (vld_s3 && (sum_s3 < best_q)) begin
			best_q <= sum_s3;
		end
		if (state_q == ST_VOL && vol_done) begin
			status_q <= npv_pkg::STATUS_OK;
			volume_q <= vol_value;
			dist_q   <= best_q;
			pcount_q <= count_q;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign volume      = volume_q;
	assign min_dist_sq = dist_q;
	assign point_count = pcount_q;

	`NPV_ASSERT_NEVER(a_count_bound, count_q > npv_pkg::MAX_COUNT, "point count above store depth")
	`NPV_ASSERT(a_append_result, (accept && opcode == npv_pkg::OP_APPEND) |=> done, "append item gave no result")
	`NPV_ASSERT_NEVER(a_scan_quiet, done && state_q == ST_SCAN, "result strobe during scan")
	`NPV_ASSERT(a_empty_dist, (done && status == npv_pkg::STATUS_EMPTY) |-> (min_dist_sq == npv_pkg::DIST_NONE && volume == '0), "empty query with distance or volume")

endmodule
